// File: hw/rtl/byte_vm_core_unit_defines.svh
// Assertion macros shared by bvm_ctrl.sv and bvm_dpath.sv.
`ifndef BYTE_VM_CORE_UNIT_DEFINES_SVH
`define BYTE_VM_CORE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define BVM_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bvm check failed: same-cycle implication");

`define BVM_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bvm check failed: next-cycle implication");

`else

`define BVM_ASSERT_IMP(label, clk, rst, pre, post)

`define BVM_ASSERT_NXT(label, clk, rst, pre, post)

`endif

`endif

// File: hw/rtl/bvm_pkg.sv
`default_nettype none
package bvm_pkg;

   localparam int MEM_DEPTH   = 65536;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);
   localparam int ADDR_W      = 17;
   localparam int STACK_DEPTH = 64;
   localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int CNT_W       = 21;
   localparam int LIMIT_W     = 20;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1000000;
   localparam logic [7:0]         LAST_OP     = 8'h1E;
   localparam logic [7:0]         SHIFT_MASK  = 8'h07;

   localparam logic CSR_START_ADDR = 1'b0;
   localparam logic CSR_INSN_LIMIT = 1'b1;

   localparam logic [7:0] OP_NOP       = 8'h00;
   localparam logic [7:0] OP_POKE      = 8'h01;
   localparam logic [7:0] OP_MOVE      = 8'h02;
   localparam logic [7:0] OP_NOT       = 8'h03;
   localparam logic [7:0] OP_NAND      = 8'h04;
   localparam logic [7:0] OP_JMP       = 8'h05;
   localparam logic [7:0] OP_JZ        = 8'h06;
   localparam logic [7:0] OP_CALL      = 8'h07;
   localparam logic [7:0] OP_HALT      = 8'h08;
   localparam logic [7:0] OP_AND       = 8'h09;
   localparam logic [7:0] OP_OR        = 8'h0A;
   localparam logic [7:0] OP_XOR       = 8'h0B;
   localparam logic [7:0] OP_INC       = 8'h0C;
   localparam logic [7:0] OP_DEC       = 8'h0D;
   localparam logic [7:0] OP_CMP       = 8'h0E;
   localparam logic [7:0] OP_SKIP      = 8'h0F;
   localparam logic [7:0] OP_PUTC      = 8'h10;
   localparam logic [7:0] OP_PUTN      = 8'h11;
   localparam logic [7:0] OP_GETC      = 8'h12;
   localparam logic [7:0] OP_RET       = 8'h13;
   localparam logic [7:0] OP_ADD       = 8'h14;
   localparam logic [7:0] OP_SUB       = 8'h15;
   localparam logic [7:0] OP_MUL       = 8'h16;
   localparam logic [7:0] OP_DIV       = 8'h17;
   localparam logic [7:0] OP_SHL       = 8'h18;
   localparam logic [7:0] OP_SHR       = 8'h19;
   localparam logic [7:0] OP_POKE_FAR  = 8'h1A;
   localparam logic [7:0] OP_MOVE_FAR  = 8'h1B;
   localparam logic [7:0] OP_JUMP_FAR  = 8'h1C;
   localparam logic [7:0] OP_JZ16      = 8'h1D;
   localparam logic [7:0] OP_CALL16    = 8'h1E;

   typedef enum logic [1:0] {
      ITEM_WRITE   = 2'd0,
      ITEM_READ    = 2'd1,
      ITEM_EXEC    = 2'd2,
      ITEM_RESTART = 2'd3
   } item_op_type;

   typedef enum logic [3:0] {
      ST_RUN       = 4'd0,
      ST_HALT      = 4'd1,
      ST_TRUNC     = 4'd2,
      ST_STK_OVER  = 4'd3,
      ST_STK_UNDER = 4'd4,
      ST_DIV_ZERO  = 4'd5,
      ST_BOUNDS    = 4'd6,
      ST_BAD_OP    = 4'd7,
      ST_LIMIT     = 4'd8,
      ST_COMMENT   = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_NUM  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_RDW, S_F_A, S_F_B, S_F_D, S_F_E, S_F_X, S_F_Y, S_F_Z,
      S_EXEC, S_DIV, S_DIVW, S_FIN
   } ctl_state_type;

   typedef enum logic [3:0] {
      RS_ITEM, RS_IP0, RS_IP1, RS_IP2, RS_IP3, RS_IP4, RS_X, RS_Y, RS_Z
   } rd_sel_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_ITEM, CAP_OP, CAP_A, CAP_B, CAP_D, CAP_E, CAP_X, CAP_Y
   } cap_sel_type;

   typedef struct packed {
      logic        accept;
      logic        item_wr;
      logic        restart;
      logic        exec_start;
      rd_sel_type  rd_sel;
      cap_sel_type cap_sel;
      logic        commit;
      logic        div_start;
      logic        div_step;
      logic        out_load;
      logic        clear;
   } ctl_cmd_type;

   typedef struct packed {
      logic running;
      logic pre_fault;
      logic need_div;
      logic div_done;
      logic clr_done;
   } dp_stat_type;

   // Instruction length in bytes, opcode byte included.
   function automatic logic [2:0] op_len(input logic [7:0] op);
      logic [2:0] len;
      case (op)
         OP_NOP, OP_HALT, OP_RET:                              len = 3'd1;
         OP_NOT, OP_JMP, OP_CALL, OP_INC, OP_DEC, OP_SKIP, OP_PUTC,
         OP_PUTN, OP_GETC:                                     len = 3'd2;
         OP_POKE, OP_MOVE, OP_JZ, OP_JUMP_FAR, OP_CALL16:      len = 3'd3;
         OP_MOVE_FAR:                                          len = 3'd5;
         default:                                              len = 3'd4;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/byte_vm_core_unit.sv
// Channel   Ports                      Contents (lowest bit first)
// request   req_tvalid/tready/tdata    tdata: address, data, char_in; tuser: opcode
// response  rsp_tvalid/tready/tdata    tdata: read_data, out_value, char_used, status,
//                                      overflow, program_counter; tuser: out_kind
// config    csr_wr_en/index/wdata      index 0 start_address, 1 instruction_limit
//
// Write, restart and stopped-machine execute items go from S_IDLE straight to
// S_FIN, reads pass S_RDW first. An executed instruction makes five fetch reads
// and three operand reads through the one read port of the byte memory, then
// executes and loads the output; DIV first runs the bit-serial divider.
// After reset a clearing pass zeroes the byte memory, with req_tready low. A
// response waiting on rsp_tready lets the next item in but holds it in S_FIN.
`default_nettype none
module byte_vm_core_unit
   import bvm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [31:0]        req_tdata,   // address, data, char_in
   input  wire logic [1:0]         req_tuser,   // opcode
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // read_data, out_value, char_used, status, overflow, program_counter, pad
   output logic [39:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,   // out_kind
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   ctl_cmd_type       cmd;
   dp_stat_type       stat;
   logic [7:0]        read_data, out_value;
   logic [1:0]        out_kind;
   logic              char_used, overflow;
   logic [3:0]        status;
   logic [ADDR_W-1:0] program_counter;

   bvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (item_op_type'(req_tuser)),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bvm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_address       (req_tdata[15:0]),
      .req_data          (req_tdata[23:16]),
      .req_char          (req_tdata[31:24]),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .o_read_data       (read_data),
      .o_out_kind        (out_kind),
      .o_out_value       (out_value),
      .o_char_used       (char_used),
      .o_status          (status),
      .o_overflow        (overflow),
      .o_program_counter (program_counter)
   );

   assign rsp_tdata = {1'b0, program_counter, overflow, status, char_used, out_value,
                       read_data};
   assign rsp_tuser = out_kind;

endmodule
`default_nettype wire

// File: hw/rtl/bvm_ctrl.sv
`default_nettype none
`include "byte_vm_core_unit_defines.svh"
module bvm_ctrl
   import bvm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire item_op_type req_op,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire dp_stat_type stat,
   output ctl_cmd_type      cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:  if (stat.clr_done) state_in = S_IDLE;
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_op == ITEM_READ) begin
                  state_in = S_RDW;
               end else if (req_op == ITEM_EXEC && stat.running && !stat.pre_fault) begin
                  state_in = S_F_A;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_RDW:  state_in = S_FIN;
         S_F_A:  state_in = S_F_B;
         S_F_B:  state_in = S_F_D;
         S_F_D:  state_in = S_F_E;
         S_F_E:  state_in = S_F_X;
         S_F_X:  state_in = S_F_Y;
         S_F_Y:  state_in = S_F_Z;
         S_F_Z:  state_in = S_EXEC;
         S_EXEC: state_in = stat.need_div ? S_DIV : S_FIN;
         S_DIV:  if (stat.div_done) state_in = S_DIVW;
         S_DIVW: state_in = S_FIN;
         S_FIN:  if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.rd_sel  = RS_ITEM;
      cmd.cap_sel = CAP_NONE;
      unique case (state_ff)
         S_CLR:  cmd.clear = !stat.clr_done;
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (req_op)
                  ITEM_WRITE:   cmd.item_wr = 1'b1;
                  ITEM_READ:    cmd.rd_sel  = RS_ITEM;
                  ITEM_RESTART: cmd.restart = 1'b1;
                  ITEM_EXEC: begin
                     cmd.exec_start = stat.running;
                     cmd.rd_sel     = RS_IP0;
                  end
                  default: ;
               endcase
            end
         end
         S_RDW: cmd.cap_sel = CAP_ITEM;
         S_F_A: begin
            cmd.cap_sel = CAP_OP;
            cmd.rd_sel  = RS_IP1;
         end
         S_F_B: begin
            cmd.cap_sel = CAP_A;
            cmd.rd_sel  = RS_IP2;
         end
         S_F_D: begin
            cmd.cap_sel = CAP_B;
            cmd.rd_sel  = RS_IP3;
         end
         S_F_E: begin
            cmd.cap_sel = CAP_D;
            cmd.rd_sel  = RS_IP4;
         end
         S_F_X: begin
            cmd.cap_sel = CAP_E;
            cmd.rd_sel  = RS_X;
         end
         S_F_Y: begin
            cmd.cap_sel = CAP_X;
            cmd.rd_sel  = RS_Y;
         end
         S_F_Z: begin
            cmd.cap_sel = CAP_Y;
            cmd.rd_sel  = RS_Z;
         end
         S_EXEC: begin
            cmd.div_start = stat.need_div;
            cmd.commit    = !stat.need_div;
         end
         S_DIV:  cmd.div_step = !stat.div_done;
         S_DIVW: cmd.commit   = 1'b1;
         S_FIN:  cmd.out_load = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `BVM_ASSERT_IMP(a_load_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_tready)
   `BVM_ASSERT_NXT(a_div_exit, clock, reset, state_ff == S_DIV && stat.div_done,
                   state_ff == S_DIVW)
   `BVM_ASSERT_NXT(a_early_fault, clock, reset,
                   cmd.exec_start && stat.pre_fault, state_ff == S_FIN)

endmodule
`default_nettype wire

// File: hw/rtl/bvm_dpath.sv
`default_nettype none
`include "byte_vm_core_unit_defines.svh"
module bvm_dpath
   import bvm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_cmd_type        cmd,
   output dp_stat_type             stat,
   input  wire logic [15:0]        req_address,
   input  wire logic [7:0]         req_data,
   input  wire logic [7:0]         req_char,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [LIMIT_W-1:0] csr_wdata,
   output logic [7:0]              o_read_data,
   output logic [1:0]              o_out_kind,
   output logic [7:0]              o_out_value,
   output logic                    o_char_used,
   output logic [3:0]              o_status,
   output logic                    o_overflow,
   output logic [ADDR_W-1:0]       o_program_counter
);

   localparam logic [ADDR_W-1:0] MEM_END = ADDR_W'(MEM_DEPTH);

   logic [15:0]        start_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [ADDR_W-1:0]  ip_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               carry_ff;
   status_type         status_ff;

   logic [7:0] op_ff, a_ff, b_ff, d_ff, e_ff, x_ff, y_ff;
   logic [7:0] char_ff, item_rd_ff, val_ff;
   kind_type   kind_ff;
   logic       used_ff;

   logic [7:0] quo_ff, rem_ff;
   logic [2:0] div_cnt_ff;
   logic       div_done_ff;
   logic [8:0] rem_sh;
   logic       rem_ge;

   logic [MEM_AW-1:0] clr_idx_ff;
   logic              clr_done_ff;

   logic [7:0]        mem [MEM_DEPTH];
   logic [7:0]        mem_q_ff;
   logic              oor_ff;
   logic [ADDR_W-1:0] raddr;
   logic [7:0]        rd_data;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   logic [15:0]       stack [STACK_DEPTH];
   logic [15:0]       stk_q_ff;
   logic [STK_AW-1:0] top_idx;

   logic [ADDR_W-1:0] ip_p1, ip_p2, ip_p3, ip_p4, ip_p5;
   logic [15:0]       t16, s16;
   logic              t16_oob, s16_oob;
   logic [15:0]       prod;
   logic [8:0]        sum9;

   logic              ex_fault;
   status_type        ex_code;
   logic [ADDR_W-1:0] ex_nip;
   logic              ex_we;
   logic [ADDR_W-1:0] ex_waddr;
   logic [7:0]        ex_wdata;
   logic              ex_carry_we, ex_carry;
   logic              ex_push, ex_pop;
   logic [15:0]       ex_push_data;
   kind_type          ex_kind;
   logic              ex_used;
   logic              ex_need_div;
   logic              limit_hit, ip_oob;

   assign ip_p1   = ip_ff + ADDR_W'(1);
   assign ip_p2   = ip_ff + ADDR_W'(2);
   assign ip_p3   = ip_ff + ADDR_W'(3);
   assign ip_p4   = ip_ff + ADDR_W'(4);
   assign ip_p5   = ip_ff + ADDR_W'(5);
   assign t16     = {a_ff, b_ff};
   assign s16     = {d_ff, e_ff};
   assign t16_oob = {1'b0, t16} >= MEM_END;
   assign s16_oob = {1'b0, s16} >= MEM_END;
   assign top_idx = STK_AW'(depth_ff - DEPTH_W'(1));

   assign count_in  = count_ff + CNT_W'(1);
   assign limit_hit = count_in > CNT_W'(limit_ff);
   assign ip_oob    = ip_ff >= MEM_END;

   // Memory read address; the read data comes back in the next cycle.
   always_comb begin
      unique case (cmd.rd_sel)
         RS_ITEM: raddr = {1'b0, req_address};
         RS_IP0:  raddr = ip_ff;
         RS_IP1:  raddr = ip_p1;
         RS_IP2:  raddr = ip_p2;
         RS_IP3:  raddr = ip_p3;
         RS_IP4:  raddr = ip_p4;
         RS_X:    raddr = ADDR_W'(a_ff);
         RS_Y:    raddr = ADDR_W'(b_ff);
         RS_Z:    raddr = (op_ff == OP_MOVE_FAR) ? {1'b0, t16} : ADDR_W'(d_ff);
         default: raddr = ip_ff;
      endcase
   end

   assign rd_data = oor_ff ? 8'h00 : mem_q_ff;

   // Instruction execute; rd_data holds the third operand read in this cycle.
   always_comb begin
      ex_fault     = 1'b0;
      ex_code      = ST_RUN;
      ex_nip       = ip_ff;
      ex_we        = 1'b0;
      ex_waddr     = ADDR_W'(d_ff);
      ex_wdata     = 8'h00;
      ex_carry_we  = 1'b0;
      ex_carry     = 1'b0;
      ex_push      = 1'b0;
      ex_pop       = 1'b0;
      ex_push_data = ip_p2[15:0];
      ex_kind      = KIND_NONE;
      ex_used      = 1'b0;
      ex_need_div  = 1'b0;
      prod         = x_ff * y_ff;
      sum9         = {1'b0, x_ff} + {1'b0, y_ff};
      if (op_ff > LAST_OP) begin
         ex_fault = 1'b1;
         ex_code  = ST_BAD_OP;
      end else if ((ip_ff + ADDR_W'(op_len(op_ff))) > MEM_END) begin
         ex_fault = 1'b1;
         ex_code  = ST_TRUNC;
      end else begin
         case (op_ff)
            OP_NOP: ex_nip = ip_p1;
            OP_POKE: begin
               ex_we = 1'b1; ex_waddr = ADDR_W'(a_ff); ex_wdata = b_ff; ex_nip = ip_p3;
            end
            OP_MOVE: begin
               ex_we = 1'b1; ex_waddr = ADDR_W'(b_ff); ex_wdata = x_ff; ex_nip = ip_p3;
            end
            OP_NOT: begin
               ex_we = 1'b1; ex_waddr = ADDR_W'(a_ff); ex_wdata = ~x_ff; ex_nip = ip_p2;
            end
            OP_NAND: begin
               ex_we = 1'b1; ex_wdata = ~(x_ff & y_ff); ex_nip = ip_p4;
            end
            OP_JMP: ex_nip = ADDR_W'(a_ff);
            OP_JZ:  ex_nip = (y_ff == 8'h00) ? ADDR_W'(a_ff) : ip_p3;
            OP_CALL, OP_CALL16: begin
               if (op_ff == OP_CALL16 && t16_oob) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_BOUNDS;
               end else if (depth_ff >= DEPTH_W'(STACK_DEPTH)) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_STK_OVER;
               end else begin
                  ex_push = 1'b1;
                  if (op_ff == OP_CALL) begin
                     ex_push_data = ip_p2[15:0];
                     ex_nip       = ADDR_W'(a_ff);
                  end else begin
                     ex_push_data = ip_p3[15:0];
                     ex_nip       = {1'b0, t16};
                  end
               end
            end
            OP_HALT, OP_RET: begin
               if (depth_ff == '0) begin
                  ex_fault = 1'b1;
                  ex_code  = (op_ff == OP_HALT) ? ST_HALT : ST_STK_UNDER;
               end else begin
                  ex_pop = 1'b1;
                  ex_nip = {1'b0, stk_q_ff};
               end
            end
            OP_AND: begin
               ex_we = 1'b1; ex_wdata = x_ff & y_ff; ex_nip = ip_p4;
            end
            OP_OR: begin
               ex_we = 1'b1; ex_wdata = x_ff | y_ff; ex_nip = ip_p4;
            end
            OP_XOR: begin
               ex_we = 1'b1; ex_wdata = x_ff ^ y_ff; ex_nip = ip_p4;
            end
            OP_INC: begin
               ex_we = 1'b1; ex_waddr = ADDR_W'(a_ff); ex_wdata = x_ff + 8'd1;
               ex_nip = ip_p2;
            end
            OP_DEC: begin
               ex_we = 1'b1; ex_waddr = ADDR_W'(a_ff); ex_wdata = x_ff - 8'd1;
               ex_nip = ip_p2;
            end
            OP_CMP: begin
               ex_we = 1'b1; ex_wdata = {7'd0, x_ff == y_ff}; ex_nip = ip_p4;
            end
            OP_SKIP: begin
               if ((ip_p2 + ADDR_W'(a_ff)) > MEM_END) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_COMMENT;
               end else begin
                  ex_nip = ip_p2 + ADDR_W'(a_ff);
               end
            end
            OP_PUTC: begin
               ex_kind = KIND_CHAR; ex_nip = ip_p2;
            end
            OP_PUTN: begin
               ex_kind = KIND_NUM; ex_nip = ip_p2;
            end
            OP_GETC: begin
               ex_we = 1'b1; ex_waddr = ADDR_W'(a_ff); ex_wdata = char_ff;
               ex_used = 1'b1; ex_nip = ip_p2;
            end
            OP_ADD: begin
               ex_we = 1'b1; ex_wdata = sum9[7:0];
               ex_carry_we = 1'b1; ex_carry = sum9[8]; ex_nip = ip_p4;
            end
            OP_SUB: begin
               ex_we = 1'b1; ex_wdata = x_ff - y_ff;
               ex_carry_we = 1'b1; ex_carry = x_ff < y_ff; ex_nip = ip_p4;
            end
            OP_MUL: begin
               ex_we = 1'b1; ex_wdata = prod[7:0];
               ex_carry_we = 1'b1; ex_carry = |prod[15:8]; ex_nip = ip_p4;
            end
            OP_DIV: begin
               if (y_ff == 8'h00) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_DIV_ZERO;
               end else begin
                  // Quotient is ready only after the divide sequence.
                  ex_need_div = 1'b1;
                  ex_we = 1'b1; ex_wdata = quo_ff; ex_nip = ip_p4;
               end
            end
            OP_SHL: begin
               ex_we = 1'b1; ex_wdata = x_ff << y_ff[2:0]; ex_nip = ip_p4;
            end
            OP_SHR: begin
               ex_we = 1'b1; ex_wdata = x_ff >> y_ff[2:0]; ex_nip = ip_p4;
            end
            OP_POKE_FAR: begin
               if (t16_oob) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_BOUNDS;
               end else begin
                  ex_we = 1'b1; ex_waddr = {1'b0, t16}; ex_wdata = d_ff; ex_nip = ip_p4;
               end
            end
            OP_MOVE_FAR: begin
               if (t16_oob || s16_oob) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_BOUNDS;
               end else begin
                  ex_we = 1'b1; ex_waddr = {1'b0, s16}; ex_wdata = rd_data; ex_nip = ip_p5;
               end
            end
            OP_JUMP_FAR: begin
               if (t16_oob) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_BOUNDS;
               end else begin
                  ex_nip = {1'b0, t16};
               end
            end
            default: begin
               if (t16_oob) begin
                  ex_fault = 1'b1;
                  ex_code  = ST_BOUNDS;
               end else begin
                  ex_nip = (rd_data == 8'h00) ? {1'b0, t16} : ip_p4;
               end
            end
         endcase
      end
   end

   // One write port: clearing pass, write items, then instruction results.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {1'b0, req_address};
      mem_wdata = req_data;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(clr_idx_ff);
         mem_wdata = 8'h00;
      end else if (cmd.item_wr) begin
         mem_we = {1'b0, req_address} < MEM_END;
      end else if (cmd.commit && !ex_fault && ex_we) begin
         mem_we    = ex_waddr < MEM_END;
         mem_waddr = ex_waddr;
         mem_wdata = ex_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr[MEM_AW-1:0]] <= mem_wdata;
      end
      mem_q_ff <= mem[raddr[MEM_AW-1:0]];
      oor_ff   <= raddr >= MEM_END;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !ex_fault && ex_push) begin
         stack[depth_ff[STK_AW-1:0]] <= ex_push_data;
      end
      stk_q_ff <= stack[top_idx];
   end

   // Restoring divider, one quotient bit per step.
   assign rem_sh = {rem_ff, quo_ff[7]};
   assign rem_ge = rem_sh >= {1'b0, y_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= x_ff;
         rem_ff <= 8'h00;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? 8'(rem_sh - {1'b0, y_ff}) : rem_sh[7:0];
         quo_ff <= {quo_ff[6:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff  <= 3'd0;
         div_done_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_cnt_ff  <= 3'd0;
         div_done_ff <= 1'b0;
      end else if (cmd.div_step) begin
         div_cnt_ff  <= div_cnt_ff + 3'd1;
         div_done_ff <= (div_cnt_ff == 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clear) begin
         clr_idx_ff  <= clr_idx_ff + MEM_AW'(1);
         clr_done_ff <= (clr_idx_ff == MEM_AW'(MEM_DEPTH - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 16'h0000;
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_START_ADDR) begin
            start_ff <= csr_wdata[15:0];
         end
         if (csr_index == CSR_INSN_LIMIT) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff     <= '0;
         depth_ff  <= '0;
         count_ff  <= '0;
         carry_ff  <= 1'b0;
         status_ff <= ST_RUN;
      end else if (cmd.restart) begin
         ip_ff     <= {1'b0, start_ff};
         depth_ff  <= '0;
         count_ff  <= '0;
         carry_ff  <= 1'b0;
         status_ff <= ST_RUN;
      end else if (cmd.exec_start) begin
         count_ff <= count_in;
         if (limit_hit) begin
            status_ff <= ST_LIMIT;
         end else if (ip_oob) begin
            status_ff <= ST_BOUNDS;
         end
      end else if (cmd.commit) begin
         if (ex_fault) begin
            status_ff <= ex_code;
         end else begin
            ip_ff <= ex_nip;
            if (ex_carry_we) begin
               carry_ff <= ex_carry;
            end
            if (ex_push) begin
               depth_ff <= depth_ff + DEPTH_W'(1);
            end else if (ex_pop) begin
               depth_ff <= depth_ff - DEPTH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff    <= req_char;
         item_rd_ff <= 8'h00;
         kind_ff    <= KIND_NONE;
         val_ff     <= 8'h00;
         used_ff    <= 1'b0;
      end else if (cmd.commit && !ex_fault) begin
         kind_ff <= ex_kind;
         val_ff  <= (ex_kind != KIND_NONE) ? x_ff : 8'h00;
         used_ff <= ex_used;
      end
      unique case (cmd.cap_sel)
         CAP_ITEM: item_rd_ff <= rd_data;
         CAP_OP:   op_ff      <= rd_data;
         CAP_A:    a_ff       <= rd_data;
         CAP_B:    b_ff       <= rd_data;
         CAP_D:    d_ff       <= rd_data;
         CAP_E:    e_ff       <= rd_data;
         CAP_X:    x_ff       <= rd_data;
         CAP_Y:    y_ff       <= rd_data;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_read_data       <= item_rd_ff;
         o_out_kind        <= kind_ff;
         o_out_value       <= val_ff;
         o_char_used       <= used_ff;
         o_status          <= status_ff;
         o_overflow        <= carry_ff;
         o_program_counter <= ip_ff;
      end
   end

   assign stat.running   = (status_ff == ST_RUN);
   assign stat.pre_fault = limit_hit || ip_oob;
   assign stat.need_div  = ex_need_div;
   assign stat.div_done  = div_done_ff;
   assign stat.clr_done  = clr_done_ff;

   `BVM_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_W'(STACK_DEPTH))
   `BVM_ASSERT_IMP(a_push_room, clock, reset, cmd.commit && !ex_fault && ex_push,
                   depth_ff < DEPTH_W'(STACK_DEPTH))
   `BVM_ASSERT_NXT(a_restart, clock, reset, cmd.restart,
                   status_ff == ST_RUN && depth_ff == '0 && count_ff == '0)

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
   import bvm_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int RANDOM_ITEMS   = 880;
   localparam logic [7:0] BAD_OPCODE = 8'hFF;

   typedef struct {
      logic [7:0]  read_data;
      kind_type    out_kind;
      logic [7:0]  out_value;
      logic        char_used;
      status_type  status;
      logic        overflow;
      logic [16:0] pc;
   } vm_result_t;

   typedef struct {
      item_op_type op;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [7:0]  ch;
      bit          typed;
      logic [7:0]  rd;
      status_type  st;
      logic [16:0] pc;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;   // address, data, char_in
   logic [1:0] req_tuser = '0;    // opcode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // read_data, out_value, char_used, status, overflow, pc, pad
   logic [1:0] rsp_tuser;         // out_kind
   logic csr_wr_en = 1'b0;
   logic csr_index = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   byte_vm_core_unit DUT (.*);

   always #4 clock = ~clock;

   // Machine state as the testbench predicts it.
   logic [7:0]  vm_mem [0:65535];
   logic [15:0] ret_stack [0:63];
   int unsigned stack_cnt;
   logic [16:0] ip;
   int unsigned exec_count;
   logic        carry;
   status_type  run_state;
   logic [15:0] start_reg;
   int unsigned limit_reg;
   int unsigned insn_bytes [0:30] = '{1, 3, 3, 2, 4, 2, 3, 2, 1, 4, 4, 4, 2, 2, 4, 2,
                                      2, 2, 2, 1, 4, 4, 4, 4, 4, 4, 4, 5, 3, 4, 3};

   vm_result_t expected_q [$];
   bit failed = 0;
   bit calm = 0;
   int sent_items = 0;
   int idle_cycles = 0;

   function automatic int unsigned mem_byte(int unsigned a);
      return (a < MEM_DEPTH) ? int'(vm_mem[a]) : 0;
   endfunction

   function automatic void exec_insn(input logic [7:0] ch, inout vm_result_t r);
      int unsigned pc, a, b, d, x, y, t16, s16, sum;
      logic [7:0] opc;
      pc = ip;
      exec_count++;
      if (exec_count > limit_reg) begin
         run_state = ST_LIMIT;
         return;
      end
      if (pc >= MEM_DEPTH) begin
         run_state = ST_BOUNDS;
         return;
      end
      opc = vm_mem[pc];
      if (opc > LAST_OP) begin
         run_state = ST_BAD_OP;
         return;
      end
      if (pc + insn_bytes[opc] > MEM_DEPTH) begin
         run_state = ST_TRUNC;
         return;
      end
      a = mem_byte(pc + 1);
      b = mem_byte(pc + 2);
      d = mem_byte(pc + 3);
      x = vm_mem[a];
      y = vm_mem[b];
      t16 = (a << 8) | b;
      s16 = (d << 8) | mem_byte(pc + 4);
      // Two bytes can never form an address beyond the store, so the
      // 16-bit bounds faults cannot occur at full memory depth.
      case (opc)
         OP_NOP: pc += 1;
         OP_POKE: begin vm_mem[a] = 8'(b); pc += 3; end
         OP_MOVE: begin vm_mem[b] = 8'(x); pc += 3; end
         OP_NOT: begin vm_mem[a] = 8'(~x); pc += 2; end
         OP_NAND: begin vm_mem[d] = 8'(~(x & y)); pc += 4; end
         OP_JMP: pc = a;
         OP_JZ: pc = (y == 0) ? a : pc + 3;
         OP_CALL, OP_CALL16: begin
            if (stack_cnt >= STACK_DEPTH) begin
               run_state = ST_STK_OVER;
               return;
            end
            ret_stack[stack_cnt] = 16'(pc + ((opc == OP_CALL) ? 2 : 3));
            stack_cnt++;
            pc = (opc == OP_CALL) ? a : t16;
         end
         OP_HALT, OP_RET: begin
            if (stack_cnt == 0) begin
               run_state = (opc == OP_HALT) ? ST_HALT : ST_STK_UNDER;
               return;
            end
            stack_cnt--;
            pc = ret_stack[stack_cnt];
         end
         OP_AND: begin vm_mem[d] = 8'(x & y); pc += 4; end
         OP_OR: begin vm_mem[d] = 8'(x | y); pc += 4; end
         OP_XOR: begin vm_mem[d] = 8'(x ^ y); pc += 4; end
         OP_INC: begin vm_mem[a] = 8'(x + 1); pc += 2; end
         OP_DEC: begin vm_mem[a] = 8'(x - 1); pc += 2; end
         OP_CMP: begin vm_mem[d] = (x == y) ? 8'd1 : 8'd0; pc += 4; end
         OP_SKIP: begin
            if (pc + 2 + a > MEM_DEPTH) begin
               run_state = ST_COMMENT;
               return;
            end
            pc += 2 + a;
         end
         OP_PUTC, OP_PUTN: begin
            r.out_value = 8'(x);
            r.out_kind = (opc == OP_PUTC) ? KIND_CHAR : KIND_NUM;
            pc += 2;
         end
         OP_GETC: begin vm_mem[a] = ch; r.char_used = 1'b1; pc += 2; end
         OP_ADD: begin
            sum = x + y;
            vm_mem[d] = 8'(sum);
            carry = (sum > 255);
            pc += 4;
         end
         OP_SUB: begin vm_mem[d] = 8'(x - y); carry = (x < y); pc += 4; end
         OP_MUL: begin
            sum = x * y;
            vm_mem[d] = 8'(sum);
            carry = (sum > 255);
            pc += 4;
         end
         OP_DIV: begin
            if (y == 0) begin
               run_state = ST_DIV_ZERO;
               return;
            end
            vm_mem[d] = 8'(x / y);
            pc += 4;
         end
         OP_SHL: begin vm_mem[d] = 8'(x << (y & SHIFT_MASK)); pc += 4; end
         OP_SHR: begin vm_mem[d] = 8'(x >> (y & SHIFT_MASK)); pc += 4; end
         OP_POKE_FAR: begin vm_mem[t16] = 8'(d); pc += 4; end
         OP_MOVE_FAR: begin vm_mem[s16] = vm_mem[t16]; pc += 5; end
         OP_JUMP_FAR: pc = t16;
         default: pc = (vm_mem[d] == 0) ? t16 : pc + 4;
      endcase
      ip = 17'(pc);
   endfunction

   function automatic vm_result_t predict_item(item_op_type op, logic [15:0] addr,
                                               logic [7:0] wdata, logic [7:0] ch);
      vm_result_t r;
      r.read_data = '0;
      r.out_kind = KIND_NONE;
      r.out_value = '0;
      r.char_used = 1'b0;
      case (op)
         ITEM_WRITE: vm_mem[addr] = wdata;
         ITEM_READ: r.read_data = vm_mem[addr];
         ITEM_RESTART: begin
            ip = {1'b0, start_reg};
            stack_cnt = 0;
            exec_count = 0;
            carry = 1'b0;
            run_state = ST_RUN;
         end
         default: if (run_state == ST_RUN) exec_insn(ch, r);
      endcase
      r.status = run_state;
      r.overflow = carry;
      r.pc = ip;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   task automatic send_item(item_op_type op, logic [15:0] addr, logic [7:0] wdata,
                            logic [7:0] ch, bit typed = 0, logic [7:0] rd = 0,
                            status_type st = ST_RUN, logic [16:0] pc = 0);
      vm_result_t r;
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {ch, wdata, addr};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      r = predict_item(op, addr, wdata, ch);
      if (typed) begin
         r.read_data = rd;
         r.status = st;
         r.pc = pc;
      end
      expected_q.push_back(r);
      sent_items++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= LIMIT_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_START_ADDR) start_reg = 16'(value);
      else limit_reg = value & 32'hFFFFF;
   endtask

   task automatic run_program(bit recurse);
      logic [15:0] base;
      logic [7:0] opc;
      int pos, len, steps;
      base = start_reg;
      repeat ($urandom_range(2, 8))
         send_item(ITEM_WRITE, 16'($urandom_range(0, 31)),
                   ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom), 8'($urandom));
      if (recurse) begin
         // A call to itself nests until the return stack overflows, unless the run stops first.
         send_item(ITEM_WRITE, base, OP_CALL16, 8'd0);
         send_item(ITEM_WRITE, base + 16'd1, base[15:8], 8'd0);
         send_item(ITEM_WRITE, base + 16'd2, base[7:0], 8'd0);
      end else begin
         pos = 0;
         while (pos < 16) begin
            opc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(31, 255))
                                              : 8'($urandom_range(0, 30));
            send_item(ITEM_WRITE, base + 16'(pos), opc, 8'($urandom));
            len = (opc <= LAST_OP) ? insn_bytes[opc] : 1;
            for (int k = 1; k < len; k++)
               send_item(ITEM_WRITE, base + 16'(pos + k),
                         $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 31)),
                         8'($urandom));
            pos += len;
         end
      end
      send_item(ITEM_RESTART, 16'($urandom), 8'($urandom), 8'($urandom));
      steps = 0;
      while (run_state == ST_RUN && steps < 70) begin
         if ($urandom_range(0, 11) == 0)
            send_item(item_op_type'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
                      8'($urandom));
         else
            send_item(ITEM_EXEC, 16'($urandom), 8'($urandom),
                      ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom));
         steps++;
      end
      // One more step, on the stopped machine if the run has ended.
      send_item(ITEM_EXEC, 16'($urandom), 8'($urandom), 8'($urandom));
   endtask

   stim_row_t directed [] = '{
      '{ITEM_READ,    16'd0,     8'h00,    8'h00, 1, 8'h00, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'hFFFF,  8'hFF,    8'h00, 1, 8'h00, ST_RUN,       17'd0},
      '{ITEM_READ,    16'hFFFF,  8'h00,    8'h00, 1, 8'hFF, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'd0,     OP_PUTN,  8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'd1,     8'h10,    8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'h10,    8'hFF,    8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_EXEC,    16'd0,     8'h00,    8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'd2,     BAD_OPCODE, 8'h00, 0, 8'h00, ST_RUN,     17'd0},
      '{ITEM_EXEC,    16'd0,     8'h00,    8'h00, 1, 8'h00, ST_BAD_OP,    17'd2},
      '{ITEM_EXEC,    16'd0,     8'h00,    8'h00, 1, 8'h00, ST_BAD_OP,    17'd2},
      '{ITEM_RESTART, 16'd0,     8'h00,    8'h00, 1, 8'h00, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'd0,     OP_GETC,  8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'd1,     8'h20,    8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_EXEC,    16'd0,     8'h00,    8'hAA, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_READ,    16'h20,    8'h00,    8'h00, 1, 8'hAA, ST_RUN,       17'd2},
      '{ITEM_WRITE,   16'd2,     OP_RET,   8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_EXEC,    16'd0,     8'h00,    8'h00, 1, 8'h00, ST_STK_UNDER, 17'd2},
      '{ITEM_RESTART, 16'd0,     8'h00,    8'h00, 1, 8'h00, ST_RUN,       17'd0},
      '{ITEM_WRITE,   16'd2,     OP_HALT,  8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_EXEC,    16'd0,     8'h00,    8'h00, 0, 8'h00, ST_RUN,       17'd0},
      '{ITEM_EXEC,    16'd0,     8'h00,    8'h00, 1, 8'h00, ST_HALT,      17'd2}
   };

   initial begin
      logic [15:0] phase_start [0:4];
      int unsigned phase_limit [0:4];
      int episode;
      for (int i = 0; i < MEM_DEPTH; i++) vm_mem[i] = 8'h00;
      start_reg = '0;
      limit_reg = LIMIT_RESET;
      ip = '0;
      stack_cnt = 0;
      exec_count = 0;
      carry = 1'b0;
      run_state = ST_RUN;
      phase_start = '{16'd0, 16'($urandom), 16'd65530, 16'hFFFF, 16'h00F0};
      phase_limit = '{32'd1048575, 32'd3, 32'd1000, 32'd1, 32'd40};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_item(directed[i].op, directed[i].addr, directed[i].data, directed[i].ch,
                   directed[i].typed, directed[i].rd, directed[i].st, directed[i].pc);
      episode = 0;
      while (sent_items < directed.size() + RANDOM_ITEMS) begin
         if (episode % 4 == 0) begin
            drain_requests();
            write_csr(CSR_START_ADDR, phase_start[(episode / 4) % 5]);
            write_csr(CSR_INSN_LIMIT, phase_limit[(episode / 4) % 5]);
         end
         run_program(episode % 4 == 1);
         episode++;
      end
      drain_requests();
      if (!failed)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Response backpressure; calm stretches have no stalls on either side.
   int stall_left = 0;
   int calm_timer = 0;
   always @(negedge clock) begin
      calm_timer <= calm_timer + 1;
      if (calm_timer % 256 == 255) calm <= ($urandom_range(0, 2) == 0);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm) stall_left <= pick_gap();
      end
   end

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         failed = 1;
      end
   endtask

   always @(posedge clock) begin
      vm_result_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("result item arrived with nothing expected");
            failed = 1;
         end else begin
            e = expected_q.pop_front();
            check_field("read_data", e.read_data, rsp_tdata[7:0]);
            check_field("out_kind", e.out_kind, rsp_tuser);
            check_field("out_value", e.out_value, rsp_tdata[15:8]);
            check_field("char_used", e.char_used, rsp_tdata[16]);
            check_field("status", e.status, rsp_tdata[20:17]);
            check_field("overflow", e.overflow, rsp_tdata[21]);
            check_field("program_counter", e.pc, rsp_tdata[38:22]);
         end
      end
   end

   // The clearing pass after reset keeps req_tready low.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_ctrl.sv
hw/rtl/bvm_dpath.sv
hw/rtl/byte_vm_core_unit.sv
tb/testbench.sv
